FILE: design/smep_pkg.sv
// Shared types and constants for the sequence event parser.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package smep_pkg;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_NOTE_ON = 3'd1,
        KIND_NOTE_OFF = 3'd2,
        KIND_PATCH   = 3'd3,
        KIND_BEND    = 3'd4,
        KIND_END     = 3'd5,
        KIND_ERROR   = 3'd6
    } kind_t;

    localparam int HEADER_BYTES = 15;
    localparam logic [7:0] META_STATUS = 8'hff;
    localparam logic [7:0] META_END    = 8'h2f;
    localparam logic [7:0] META_TEMPO  = 8'h51;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         seq_id;
        logic [31:0]        tick;
        logic [3:0]         channel;
        logic [7:0]         note;
        logic [7:0]         velocity;
        logic [7:0]         patch;
        logic signed [11:0] bend;
        logic [23:0]        tempo;
        logic [15:0]        ticks_per_beat;
        logic [7:0]         beats_per_bar;
    } out_item_t;

    // Commands from the controller to the datapath for one byte.
    typedef struct packed {
        logic start;      // bar rounding: begin the divide
        logic emit;       // result register is loaded
        logic [2:0] kind;
    } smep_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } smep_stat_t;

endpackage
`default_nettype wire

FILE: design/smep_div.sv
// Sequential unsigned divider used for end-of-track bar rounding.
// Depends on nothing but smep_pkg for style; restoring, one bit per cycle.
`default_nettype none
module smep_div
    import smep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [32:0] dividend,
    input  wire logic [23:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [32:0]      quotient
);
    logic [5:0]  cnt_reg;
    logic [32:0] q_reg;
    logic [24:0] rem_reg;
    logic [23:0] dv_reg;
    logic [24:0] trial;
    logic        busy_reg;
    logic        done_reg;

    assign trial = {rem_reg[23:0], q_reg[32]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dv_reg})
            begin
                rem_reg <= trial - {1'b0, dv_reg};
                q_reg   <= {q_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[31:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

FILE: design/smep_datapath.sv
// Datapath of the sequence event parser: header fields, tick, result register.
// Depends on smep_pkg and smep_div.
`default_nettype none
module smep_datapath
    import smep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire smep_cmd_t   cmd,
    input  wire logic [31:0] tick,
    input  wire logic [3:0]  channel,
    input  wire logic [7:0]  note,
    input  wire logic [7:0]  velocity,
    input  wire logic [7:0]  patch,
    input  wire logic [15:0] bend_raw,
    input  wire logic [23:0] tempo,
    input  wire logic [15:0] tpb,
    input  wire logic [7:0]  beats,
    input  wire logic [7:0]  seq_id,
    output smep_stat_t       stat,
    output out_item_t        result
);
    logic [23:0] bar_reg;
    logic [31:0] div_tick_reg;
    logic        busy;
    logic        done;
    logic [32:0] quo;
    logic [56:0] prod;
    logic signed [16:0] braw;
    logic signed [27:0] bmul;
    logic signed [27:0] bq;
    logic        pending_reg;

    // Bend: (raw*508 - 508*16383)/16383. The numerator takes either sign, so the
    // magnitude is divided and the sign put back, which truncates toward zero.
    assign braw = {bend_raw[15], bend_raw};
    assign bmul = 28'(braw) * 28'sd508 - 28'sd8322564;
    // Quotient of a non-negative value below 2^25 by 16383 via reciprocal.
    always_comb
    begin
        logic        neg;
        logic [27:0] n;
        logic [45:0] m;
        logic [27:0] qq;
        neg = bmul[27];
        n   = neg ? 28'(-bmul) : bmul;
        m   = 46'(n) * 46'd262160;
        qq  = 28'(m >> 32);
        if (n >= 28'(qq * 28'd16383 + 28'd16383))
            qq = qq + 28'd1;
        bq = neg ? -$signed(qq) : $signed(qq);
    end

    assign prod = 57'(quo) * 57'(bar_reg);

    smep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dividend (33'(tick) + 33'(tpb * beats) - 33'd1),
        .divisor  (24'(tpb * beats)),
        .busy     (busy),
        .done     (done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bar_reg      <= 24'(tpb * beats);
            div_tick_reg <= tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 1'b0;
        else if (cmd.start)
            pending_reg <= 1'b1;
        else if (done)
            pending_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result          <= '0;
            result.kind     <= cmd.kind;
            result.seq_id   <= seq_id;
            result.tick     <= tick;
            result.channel  <= channel;
            result.note     <= note;
            result.velocity <= velocity;
            result.patch    <= patch;
            if (cmd.kind == KIND_BEND)
                result.bend <= bq[11:0];
            if (cmd.kind == KIND_HEADER)
            begin
                result.tempo          <= tempo;
                result.ticks_per_beat <= tpb;
                result.beats_per_bar  <= beats;
            end
        end
        else if (done && pending_reg)
        begin
            result        <= '0;
            result.kind   <= KIND_END;
            result.seq_id <= seq_id;
            result.tick   <= (bar_reg == '0) ? div_tick_reg : prod[31:0];
        end
    end

    assign stat.busy = busy | cmd.start;
    assign stat.done = done & pending_reg;
endmodule
`default_nettype wire

FILE: design/smep_ctrl.sv
// Controller of the sequence event parser: parse phases and per-byte state.
// Depends on smep_pkg.
`default_nettype none
module smep_ctrl
    import smep_pkg::*;
#(
    parameter int VARLEN_MAX_BYTES = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_fire,
    input  wire in_item_t    item,
    input  wire smep_stat_t  stat,
    output smep_cmd_t        cmd,
    output logic [31:0]      tick,
    output logic [3:0]       channel,
    output logic [7:0]       note,
    output logic [7:0]       velocity,
    output logic [7:0]       patch,
    output logic [15:0]      bend_raw,
    output logic [23:0]      tempo,
    output logic [15:0]      tpb,
    output logic [7:0]       beats
);
    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_DELTA, PH_STATUS, PH_META_CMD, PH_META_LEN,
        PH_SKIP, PH_NOTE1, PH_NOTE2, PH_PROG, PH_BEND1, PH_BEND2, PH_SYSLEN,
        PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  run_reg, run_next;
    logic [7:0]  cur_reg, cur_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  fd_reg, fd_next;
    logic [31:0] skip_reg, skip_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [15:0] tpb_reg, tpb_next;
    logic [7:0]  beats_reg, beats_next;
    smep_cmd_t   cmd_next;

    always_comb
    begin
        phase_t     ph;
        logic [7:0] b;
        logic [7:0] st;
        logic [31:0] acc;
        logic [3:0]  cn;
        logic       fin;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        cur_next   = cur_reg;
        tick_next  = tick_reg;
        acc_next   = acc_reg;
        fd_next    = fd_reg;
        skip_next  = skip_reg;
        tempo_next = tempo_reg;
        tpb_next   = tpb_reg;
        beats_next = beats_reg;
        cmd_next   = '0;
        b  = item.data_byte;
        ph = phase_reg;
        st = 8'h00;
        acc = {acc_reg[24:0], b[6:0]};
        cn  = cnt_reg + 4'd1;
        fin = !b[7] || (cn >= 4'(VARLEN_MAX_BYTES));
        if (in_fire)
        begin
            if (item.first_byte)
            begin
                ph = PH_HDR;
                cnt_next = '0; run_next = '0; cur_next = '0; tick_next = '0;
                acc_next = '0; fd_next = '0; skip_next = '0;
                tempo_next = '0; tpb_next = '0; beats_next = '0;
                cn = 4'd1;
                acc = {25'd0, b[6:0]};
            end
            // A data byte in status position dispatches on running status.
            if (ph == PH_STATUS)
            begin
                if (b[7])
                begin
                    st = b;
                    run_next = b;
                end
                else
                    st = run_reg;
                if (!b[7] && run_reg == 8'h00)
                begin
                    ph = PH_HALT;
                    cmd_next.emit = 1'b1;
                    cmd_next.kind = KIND_ERROR;
                end
                else
                begin
                    cur_next = st;
                    if (st == META_STATUS)
                        ph = PH_META_CMD;
                    else
                    begin
                        unique case (st[7:4])
                            4'h8, 4'h9: ph = PH_NOTE1;
                            4'hc: ph = PH_PROG;
                            4'he: ph = PH_BEND1;
                            4'ha, 4'hb: begin ph = PH_SKIP; skip_next = 32'd2; end
                            4'hd: begin ph = PH_SKIP; skip_next = 32'd1; end
                            default: begin ph = PH_SYSLEN; cnt_next = '0; acc_next = '0; end
                        endcase
                    end
                end
                phase_next = ph;
                if (!b[7] && run_reg != 8'h00)
                begin
                    // Re-consume this byte in the dispatched phase.
                    unique case (ph)
                        PH_META_CMD: begin fd_next = b; phase_next = PH_META_LEN; end
                        PH_NOTE1:    begin fd_next = b; phase_next = PH_NOTE2; end
                        PH_BEND1:    begin fd_next = b; phase_next = PH_BEND2; end
                        PH_PROG:
                        begin
                            cmd_next.emit = 1'b1; cmd_next.kind = KIND_PATCH;
                            phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                        end
                        PH_SKIP:
                        begin
                            skip_next = skip_next - 32'd1;
                            if (skip_next == 32'd0)
                            begin
                                phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                            end
                        end
                        PH_SYSLEN:
                        begin
                            acc = {25'd0, b[6:0]};
                            cn = 4'd1;
                            fin = 1'b1;
                            acc_next = acc; cnt_next = cn;
                            skip_next = acc;
                            if (acc == '0)
                            begin
                                phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                            end
                            else
                                phase_next = PH_SKIP;
                        end
                        default: phase_next = ph;
                    endcase
                end
            end
            else
            begin
                unique case (ph)
                    PH_HDR:
                    begin
                        cn = (item.first_byte ? 4'd0 : cnt_reg);
                        if (cn == 4'd8) tpb_next = {b, 8'h00};
                        else if (cn == 4'd9) tpb_next = {tpb_next[15:8], b};
                        else if (cn >= 4'd10 && cn <= 4'd12)
                            tempo_next = {tempo_next[15:0], b};
                        else if (cn == 4'd14) beats_next = b;
                        cnt_next = cn + 4'd1;
                        phase_next = PH_HDR;
                        if (cn + 4'd1 >= 4'(HEADER_BYTES))
                        begin
                            phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                            cmd_next.emit = 1'b1; cmd_next.kind = KIND_HEADER;
                        end
                    end
                    PH_DELTA:
                    begin
                        acc_next = acc; cnt_next = cn;
                        if (fin)
                        begin
                            tick_next = tick_reg + acc;
                            phase_next = PH_STATUS;
                        end
                    end
                    PH_META_CMD: begin fd_next = b; phase_next = PH_META_LEN; end
                    PH_META_LEN:
                    begin
                        if (fd_reg == META_END)
                        begin
                            phase_next = PH_HALT;
                            cmd_next.start = 1'b1;
                        end
                        else
                        begin
                            skip_next = (fd_reg == META_TEMPO) ? 32'd3 : {24'd0, b};
                            if (fd_reg != META_TEMPO && b == 8'h00)
                            begin
                                phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                            end
                            else
                                phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (skip_reg <= 32'd1)
                        begin
                            skip_next = '0;
                            phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                        end
                        else
                            skip_next = skip_reg - 32'd1;
                    end
                    PH_NOTE1: begin fd_next = b; phase_next = PH_NOTE2; end
                    PH_NOTE2:
                    begin
                        cmd_next.emit = 1'b1;
                        cmd_next.kind = (cur_reg[7:4] == 4'h9 && b != 8'h00)
                            ? KIND_NOTE_ON : KIND_NOTE_OFF;
                        phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                    end
                    PH_PROG:
                    begin
                        cmd_next.emit = 1'b1; cmd_next.kind = KIND_PATCH;
                        phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                    end
                    PH_BEND1: begin fd_next = b; phase_next = PH_BEND2; end
                    PH_BEND2:
                    begin
                        cmd_next.emit = 1'b1; cmd_next.kind = KIND_BEND;
                        phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                    end
                    PH_SYSLEN:
                    begin
                        acc_next = acc; cnt_next = cn;
                        if (fin)
                        begin
                            skip_next = acc;
                            if (acc == '0)
                            begin
                                phase_next = PH_DELTA; cnt_next = '0; acc_next = '0;
                            end
                            else
                                phase_next = PH_SKIP;
                        end
                    end
                    default: phase_next = ph;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            run_reg   <= '0;
            cur_reg   <= '0;
            tick_reg  <= '0;
            acc_reg   <= '0;
            fd_reg    <= '0;
            skip_reg  <= '0;
            tempo_reg <= '0;
            tpb_reg   <= '0;
            beats_reg <= '0;
            cmd       <= '0;
            note      <= '0;
            velocity  <= '0;
            patch     <= '0;
            bend_raw  <= '0;
            channel   <= '0;
            tick      <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            cur_reg   <= cur_next;
            tick_reg  <= tick_next;
            acc_reg   <= acc_next;
            fd_reg    <= fd_next;
            skip_reg  <= skip_next;
            tempo_reg <= tempo_next;
            tpb_reg   <= tpb_next;
            beats_reg <= beats_next;
            cmd       <= cmd_next;
            // Result fields staged alongside the command.
            note      <= '0;
            velocity  <= '0;
            patch     <= '0;
            bend_raw  <= '0;
            channel   <= (cmd_next.kind == KIND_HEADER || cmd_next.kind == KIND_ERROR
                          || cmd_next.start) ? 4'h0 : cur_next[3:0];
            tick      <= (cmd_next.kind == KIND_HEADER && cmd_next.emit) ? 32'd0
                                                                          : tick_next;
            if (cmd_next.kind == KIND_NOTE_ON || cmd_next.kind == KIND_NOTE_OFF)
            begin
                note     <= fd_reg;
                velocity <= item.data_byte;
            end
            if (cmd_next.kind == KIND_PATCH)
                patch <= item.data_byte;
            if (cmd_next.kind == KIND_BEND)
                bend_raw <= {item.data_byte, fd_reg};
        end
    end

    assign tempo = tempo_reg;
    assign tpb   = tpb_reg;
    assign beats = beats_reg;

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.start))
        else $error("emit and divide start together");
    a_halt_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> phase_reg == PH_HALT)
        else $error("divide started outside end of track");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && !(in_fire && item.first_byte)) |=> !cmd.emit)
        else $error("result while idle");
`endif
endmodule
`default_nettype wire

FILE: design/seq_midi_event_parser_unit.sv
// Sequence event parser: takes one stream byte per transfer and gives events.
// A byte is taken in any cycle in which no result is waiting or being formed;
// its command is registered in the controller and the result then in the datapath's
// result register, and input stays stalled until that result is taken. End
// of track runs a one-bit-per-cycle divider for the bar rounding, and its
// result is registered once the divider is done. Depends on smep_pkg, smep_ctrl,
// smep_datapath, smep_div.
`default_nettype none
module seq_midi_event_parser_unit
    import smep_pkg::*;
#(
    parameter int VARLEN_MAX_BYTES = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);
    logic [7:0]  stream_id_reg;
    logic        out_valid_reg;
    logic        in_fire;
    smep_cmd_t   cmd;
    smep_stat_t  stat;
    logic [31:0] tick;
    logic [3:0]  channel;
    logic [7:0]  note, velocity, patch, beats;
    logic [15:0] bend_raw, tpb;
    logic [23:0] tempo;
    logic        inflight;

    // A byte may be in the staging register; hold input until result slot clears.
    assign inflight = cmd.emit | cmd.start | stat.busy | stat.done;
    assign in_ready = !inflight && !out_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_id_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                stream_id_reg <= cfg_data;
            if (cmd.emit || stat.done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    smep_ctrl #(.VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .item(in_data), .stat(stat),
        .cmd(cmd), .tick(tick), .channel(channel), .note(note), .velocity(velocity),
        .patch(patch), .bend_raw(bend_raw), .tempo(tempo), .tpb(tpb), .beats(beats)
    );

    smep_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .tick(tick), .channel(channel),
        .note(note), .velocity(velocity), .patch(patch), .bend_raw(bend_raw),
        .tempo(tempo), .tpb(tpb), .beats(beats), .seq_id(stream_id_reg),
        .stat(stat), .result(out_data)
    );

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire
